// File: sv/jes_pkg.sv
// ----------------------------------------------------------------------------
// jes_pkg
// shared constants and types for the jacobi eigen solver core
// ----------------------------------------------------------------------------
package jes_pkg;
    localparam int WORD_W = 32;
    // largest matrix the element and result index fields can address
    localparam int MATRIX_DIM = 4;
    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    // divider request/response
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

    // square root request/response
    typedef struct packed {
        logic        start;
        logic [63:0] rad;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = SAT_MAX;
        else if (v < -66'sd2147483648)
            r = SAT_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        logic [63:0] r;
        r = v[63] ? (64'd0 - v) : v;
        return r;
    endfunction
endpackage

// File: sv/jacobi_eigen_solver_core.sv
// ----------------------------------------------------------------------------
// jacobi_eigen_solver_core
// classical jacobi eigen solver over a loaded symmetric matrix
// ----------------------------------------------------------------------------
// s_axis takes one upper-triangle element per request (tlast flags the last
// element). the last element starts the solve: pivot search over the
// off-diagonal entries (one per cycle), then per rotation one shared divider
// (four quotients) and one shared square root unit (two roots, one on the
// large-theta path), then the row and vector updates through one shared
// multiplier. once the solve ends the diagonal entries are ranked by
// magnitude, then each rank takes a square root for its mass item before
// its results go out.
// results leave on m_axis: per rank a mass item then n component items,
// tlast on the final one. s_axis_tready is low from the last element
// until the final result is registered on m_axis; a stalled m_axis holds
// its request. reset clears control, sets the vector store to identity and
// the registers to their defaults. the matrix store has no reset.
// ----------------------------------------------------------------------------
module jacobi_eigen_solver_core #(
    parameter int FRACTION_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // row_index[1:0], col_index[3:2], element_value[35:4], zero fill
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // rank_index[1:0], component_index[3:2], out_value[35:4],
    // eigen_value[67:36], not_converged[68], zero fill
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // item_kind
    output logic        m_axis_tuser
);
    import jes_pkg::*;

    localparam int IW = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;
    localparam int NW = $clog2(MATRIX_DIM + 1);
    localparam logic [63:0] ONE_Q = 64'd1 << FRACTION_BITS;

    localparam logic [1:0] REG_SIZE = 2'd0;
    localparam logic [1:0] REG_THR  = 2'd1;
    localparam logic [1:0] REG_TH2  = 2'd2;
    localparam logic [1:0] REG_MAXR = 2'd3;

    localparam logic [4:0] ST_LOAD   = 5'd0;
    localparam logic [4:0] ST_PIV    = 5'd1;
    localparam logic [4:0] ST_DECIDE = 5'd2;
    localparam logic [4:0] ST_THETA  = 5'd3;
    localparam logic [4:0] ST_TH2    = 5'd4;
    localparam logic [4:0] ST_T      = 5'd5;
    localparam logic [4:0] ST_TDIV   = 5'd6;
    localparam logic [4:0] ST_T2     = 5'd7;
    localparam logic [4:0] ST_C      = 5'd8;
    localparam logic [4:0] ST_S      = 5'd9;
    localparam logic [4:0] ST_TAU    = 5'd10;
    localparam logic [4:0] ST_DIAG   = 5'd11;
    localparam logic [4:0] ST_ROT    = 5'd12;
    localparam logic [4:0] ST_RANK   = 5'd13;
    localparam logic [4:0] ST_MASS   = 5'd14;
    localparam logic [4:0] ST_OUT    = 5'd15;
    localparam logic [4:0] ST_WAITD  = 5'd16;
    localparam logic [4:0] ST_WAITS  = 5'd17;
    localparam logic [4:0] ST_TDEN   = 5'd18;
    localparam logic [4:0] ST_CDIV   = 5'd19;

    // rotate_pair sub steps
    localparam logic [2:0] RP_RD  = 3'd0;
    localparam logic [2:0] RP_M1  = 3'd1;
    localparam logic [2:0] RP_M2  = 3'd2;
    localparam logic [2:0] RP_M3  = 3'd3;
    localparam logic [2:0] RP_M4  = 3'd4;
    localparam logic [2:0] RP_WR  = 3'd5;

    logic [2:0]  size_reg;
    logic [30:0] thr_reg, th2lim_reg;
    logic [15:0] maxr_reg;

    logic signed [31:0] amat [MATRIX_DIM][MATRIX_DIM];
    logic signed [31:0] vmat_reg [MATRIX_DIM][MATRIX_DIM];

    logic [4:0]  st_reg, ret_reg;
    logic        open_reg;
    logic [15:0] rot_reg;
    logic [IW-1:0] pr_reg, pc_reg, i_reg, j_reg;
    logic [31:0] best_reg;
    logic        nc_reg, vphase_reg;
    logic [2:0]  rp_reg;
    logic signed [31:0] theta_reg, t_reg, c_reg, s_reg, tau_reg;
    logic [63:0] th2_reg;
    logic signed [31:0] g_reg, h_reg, x_reg;
    logic [IW-1:0] rank_reg [MATRIX_DIM];
    logic [MATRIX_DIM-1:0] used_reg;
    logic [IW-1:0] pick_reg;
    logic        have_reg;
    logic [31:0] small_reg;
    logic [IW-1:0] k_reg;
    logic [NW-1:0] comp_reg;
    logic        neg_reg;

    logic        ov_reg;
    logic [71:0] od_reg;
    logic        ol_reg, ou_reg;

    div_req_t  dreq;
    div_rsp_t  drsp;
    sqrt_req_t sreq;
    sqrt_rsp_t srsp;

    jes_div  u_div  (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
    jes_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sreq), .rsp(srsp));

    logic [NW-1:0] n_dim;
    always_comb
    begin
        if (size_reg < 3'd2)
            n_dim = NW'(2);
        else if (32'(size_reg) > MATRIX_DIM)
            n_dim = NW'(MATRIX_DIM);
        else
            n_dim = NW'(size_reg);
    end

    // shared multiplier: q-format product truncated toward zero, saturated
    logic signed [31:0] mul_a, mul_b, mul_q;
    logic signed [63:0] mul_p;
    logic [63:0]        mul_m;
    always_comb
    begin
        mul_p = 64'(mul_a) * 64'(mul_b);
        mul_m = mag64(mul_p) >> FRACTION_BITS;
        mul_q = sat32(mul_p[63] ? -$signed({2'b00, mul_m}) : $signed({2'b00, mul_m}));
    end

    // shared squarer: theta squared, then t squared
    logic [31:0] sq_in;
    logic [63:0] sq_val;
    always_comb
    begin
        if (st_reg == ST_T2)
            sq_in = 32'(mag64(64'(t_reg)));
        else
            sq_in = 32'(mag64(64'(theta_reg)));
        sq_val = (64'(sq_in) * 64'(sq_in)) >> FRACTION_BITS;
    end

    logic [IW:0] ip1;
    assign ip1 = {1'b0, i_reg} + 1'b1;

    logic in_ok;
    logic [1:0] in_r, in_c;
    logic signed [31:0] in_v;
    assign in_ok = s_axis_tvalid && s_axis_tready;
    assign in_r  = (s_axis_tdata[1:0] > s_axis_tdata[3:2]) ? s_axis_tdata[3:2] : s_axis_tdata[1:0];
    assign in_c  = (s_axis_tdata[1:0] > s_axis_tdata[3:2]) ? s_axis_tdata[1:0] : s_axis_tdata[3:2];
    assign in_v  = s_axis_tdata[35:4];
    assign s_axis_tready = (st_reg == ST_LOAD);

    logic out_free;
    assign out_free = !ov_reg || m_axis_tready;

    // element addresses for the rotation step
    logic [IW-1:0] ga_r, ga_c, ha_r, ha_c;
    always_comb
    begin
        ga_r = (i_reg <= pr_reg) ? i_reg : pr_reg;
        ga_c = (i_reg <= pr_reg) ? pr_reg : i_reg;
        ha_r = (i_reg <= pc_reg) ? i_reg : pc_reg;
        ha_c = (i_reg <= pc_reg) ? pc_reg : i_reg;
    end

    logic signed [31:0] apq, app, aqq;
    assign apq = amat[pr_reg][pc_reg];
    assign app = amat[pr_reg][pr_reg];
    assign aqq = amat[pc_reg][pc_reg];

    logic [31:0] cur_mag, diag_mag;
    assign cur_mag  = 32'(mag64(64'(amat[i_reg][j_reg])));
    assign diag_mag = 32'(mag64(64'(amat[j_reg][j_reg])));

    // ranking: does the entry at j_reg beat the best so far
    logic          rank_take, rank_end;
    logic [IW-1:0] rank_sel;
    assign rank_take = !used_reg[j_reg] && (!have_reg || diag_mag < small_reg);
    assign rank_end  = (NW'(j_reg) + 1'b1 >= n_dim);
    assign rank_sel  = rank_take ? j_reg : pick_reg;

    always_comb
    begin
        mul_a = s_reg;
        mul_b = x_reg;
        case (st_reg)
            ST_S:    begin mul_a = t_reg; mul_b = c_reg; end
            ST_DIAG: begin mul_a = t_reg; mul_b = apq; end
            default:
            begin
                if (rp_reg == RP_M1 || rp_reg == RP_M2)
                begin
                    mul_a = tau_reg;
                    mul_b = (rp_reg == RP_M1) ? g_reg : h_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= 3'd4;
            thr_reg    <= 31'd1;
            th2lim_reg <= 31'h7fffffff;
            maxr_reg   <= 16'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SIZE: size_reg   <= cfg_data[2:0];
                REG_THR:  thr_reg    <= cfg_data;
                REG_TH2:  th2lim_reg <= cfg_data;
                REG_MAXR: maxr_reg   <= cfg_data[15:0];
                default:  ;
            endcase
        end
    end

    // matrix store: no reset
    always_ff @(posedge clk)
    begin
        if (in_ok && (NW'(in_c) < n_dim))
            amat[in_r[IW-1:0]][in_c[IW-1:0]] <= in_v;
        else if (st_reg == ST_DIAG)
        begin
            amat[pr_reg][pr_reg] <= sat32(66'(app) - 66'(mul_q));
            amat[pc_reg][pc_reg] <= sat32(66'(aqq) + 66'(mul_q));
            amat[pr_reg][pc_reg] <= '0;
        end
        else if (st_reg == ST_ROT && rp_reg == RP_WR && !vphase_reg
                 && i_reg != pr_reg && i_reg != pc_reg)
        begin
            amat[ga_r][ga_c] <= g_reg;
            amat[ha_r][ha_c] <= h_reg;
        end
    end

    logic signed [31:0] sum_tmp;
    always_comb
    begin
        sum_tmp = '0;
        case (rp_reg)
            RP_M1: sum_tmp = sat32(66'(h_reg) + 66'(mul_q));
            RP_M2: sum_tmp = sat32(66'(g_reg) - 66'(mul_q));
            default: sum_tmp = '0;
        endcase
    end

    logic signed [31:0] y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_LOAD;
            ret_reg  <= ST_LOAD;
            open_reg <= 1'b0;
            rot_reg  <= '0;
            pr_reg   <= '0;
            pc_reg   <= IW'(1);
            i_reg    <= '0;
            j_reg    <= '0;
            rp_reg   <= RP_RD;
            ov_reg   <= 1'b0;
            used_reg <= '0;
            have_reg <= 1'b0;
            for (int a = 0; a < MATRIX_DIM; a++)
            begin
                rank_reg[a] <= '0;
                for (int b = 0; b < MATRIX_DIM; b++)
                    vmat_reg[a][b] <= (a == b) ? 32'(ONE_Q) : '0;
            end
        end
        else
        begin
            if (st_reg == ST_OUT && out_free)
                ov_reg <= 1'b1;
            else if (m_axis_tready)
                ov_reg <= 1'b0;
            case (st_reg)
                ST_LOAD:
                begin
                    if (in_ok)
                    begin
                        if (!open_reg)
                        begin
                            for (int a = 0; a < MATRIX_DIM; a++)
                                for (int b = 0; b < MATRIX_DIM; b++)
                                    vmat_reg[a][b] <= (a == b) ? 32'(ONE_Q) : '0;
                        end
                        open_reg <= !s_axis_tlast;
                        if (s_axis_tlast)
                        begin
                            rot_reg  <= '0;
                            st_reg   <= ST_PIV;
                            i_reg    <= '0;
                            j_reg    <= IW'(1);
                            best_reg <= '0;
                            pr_reg   <= '0;
                            pc_reg   <= IW'(1);
                        end
                    end
                end
                ST_PIV:
                begin
                    if (cur_mag > best_reg)
                    begin
                        best_reg <= cur_mag;
                        pr_reg   <= i_reg;
                        pc_reg   <= j_reg;
                    end
                    if (NW'(j_reg) + 1'b1 < n_dim)
                        j_reg <= j_reg + 1'b1;
                    else if (NW'(ip1) + 1'b1 < n_dim)
                    begin
                        i_reg <= ip1[IW-1:0];
                        j_reg <= ip1[IW-1:0] + 1'b1;
                    end
                    else
                        st_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    nc_reg <= best_reg > 32'(thr_reg);
                    if (best_reg > 32'(thr_reg) && rot_reg < maxr_reg)
                    begin
                        // theta = diff*one / (2 apq)
                        neg_reg <= (64'(aqq) - 64'(app) < 0) != apq[31];
                        st_reg  <= ST_WAITD;
                        ret_reg <= ST_THETA;
                    end
                    else
                    begin
                        st_reg   <= ST_RANK;
                        i_reg    <= '0;
                        j_reg    <= '0;
                        used_reg <= '0;
                        have_reg <= 1'b0;
                    end
                end
                ST_WAITD:
                begin
                    if (drsp.done)
                        st_reg <= ret_reg;
                end
                ST_WAITS:
                begin
                    if (srsp.done)
                        st_reg <= ret_reg;
                end
                ST_THETA:
                begin
                    theta_reg <= sat32(neg_reg ? -$signed({2'b00, drsp.quo})
                                               : $signed({2'b00, drsp.quo}));
                    st_reg <= ST_TH2;
                end
                ST_TH2:
                begin
                    th2_reg <= sq_val;
                    st_reg  <= ST_T;
                end
                ST_T:
                begin
                    neg_reg <= theta_reg[31];
                    if (th2_reg > 64'(th2lim_reg))
                    begin
                        st_reg  <= ST_WAITD;
                        ret_reg <= ST_TDIV;
                    end
                    else
                    begin
                        st_reg  <= ST_WAITS;
                        ret_reg <= ST_TDEN;
                    end
                end
                ST_TDEN:
                begin
                    st_reg  <= ST_WAITD;
                    ret_reg <= ST_TDIV;
                end
                ST_TDIV:
                begin
                    t_reg <= sat32(neg_reg ? -$signed({2'b00, drsp.quo})
                                           : $signed({2'b00, drsp.quo}));
                    st_reg <= ST_T2;
                end
                ST_T2:
                begin
                    st_reg  <= ST_WAITS;
                    ret_reg <= ST_CDIV;
                end
                ST_CDIV:
                begin
                    st_reg  <= ST_WAITD;
                    ret_reg <= ST_C;
                end
                ST_C:
                begin
                    c_reg  <= sat32({2'b00, drsp.quo});
                    st_reg <= ST_S;
                end
                ST_S:
                begin
                    s_reg  <= mul_q;
                    st_reg <= ST_TAU;
                    neg_reg <= mul_q[31];
                    ret_reg <= ST_TAU;
                end
                ST_TAU:
                begin
                    if (drsp.done)
                    begin
                        tau_reg <= sat32(neg_reg ? -$signed({2'b00, drsp.quo})
                                                 : $signed({2'b00, drsp.quo}));
                        st_reg  <= ST_DIAG;
                    end
                end
                ST_DIAG:
                begin
                    st_reg     <= ST_ROT;
                    i_reg      <= '0;
                    vphase_reg <= 1'b0;
                    rp_reg     <= RP_RD;
                end
                ST_ROT:
                begin
                    case (rp_reg)
                        RP_RD:
                        begin
                            if (!vphase_reg && (i_reg == pr_reg || i_reg == pc_reg))
                                rp_reg <= RP_WR;
                            else
                            begin
                                g_reg  <= vphase_reg ? vmat_reg[i_reg][pr_reg] : amat[ga_r][ga_c];
                                h_reg  <= vphase_reg ? vmat_reg[i_reg][pc_reg] : amat[ha_r][ha_c];
                                rp_reg <= RP_M1;
                            end
                        end
                        RP_M1: begin x_reg <= sum_tmp; rp_reg <= RP_M2; end
                        RP_M2: begin y_reg <= sum_tmp; rp_reg <= RP_M3; end
                        RP_M3:
                        begin
                            g_reg  <= sat32(66'(g_reg) - 66'(mul_q));
                            x_reg  <= y_reg;
                            rp_reg <= RP_M4;
                        end
                        RP_M4:
                        begin
                            h_reg  <= sat32(66'(h_reg) + 66'(mul_q));
                            rp_reg <= RP_WR;
                        end
                        default:
                        begin
                            if (vphase_reg)
                            begin
                                vmat_reg[i_reg][pr_reg] <= g_reg;
                                vmat_reg[i_reg][pc_reg] <= h_reg;
                            end
                            rp_reg <= RP_RD;
                            if (NW'(ip1) < n_dim)
                                i_reg <= ip1[IW-1:0];
                            else if (!vphase_reg)
                            begin
                                vphase_reg <= 1'b1;
                                i_reg      <= '0;
                            end
                            else
                            begin
                                rot_reg  <= rot_reg + 16'd1;
                                st_reg   <= ST_PIV;
                                i_reg    <= '0;
                                j_reg    <= IW'(1);
                                best_reg <= '0;
                                pr_reg   <= '0;
                                pc_reg   <= IW'(1);
                            end
                        end
                    endcase
                end
                ST_RANK:
                begin
                    // selection sort pass, one diagonal entry a cycle
                    if (rank_end)
                    begin
                        rank_reg[i_reg]    <= rank_sel;
                        used_reg[rank_sel] <= 1'b1;
                        have_reg           <= 1'b0;
                        j_reg              <= '0;
                        if (NW'(ip1) < n_dim)
                            i_reg <= ip1[IW-1:0];
                        else
                        begin
                            i_reg  <= '0;
                            st_reg <= ST_MASS;
                        end
                    end
                    else
                    begin
                        if (rank_take)
                        begin
                            pick_reg  <= j_reg;
                            small_reg <= diag_mag;
                            have_reg  <= 1'b1;
                        end
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_MASS:
                begin
                    k_reg    <= rank_reg[i_reg];
                    st_reg   <= ST_WAITS;
                    ret_reg  <= ST_OUT;
                    comp_reg <= '0;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        if (NW'(comp_reg) == n_dim && NW'(ip1) >= n_dim)
                        begin
                            st_reg <= ST_LOAD;
                        end
                        else if (NW'(comp_reg) == n_dim)
                        begin
                            i_reg  <= ip1[IW-1:0];
                            st_reg <= ST_MASS;
                        end
                        else
                            comp_reg <= comp_reg + 1'b1;
                    end
                end
                default: st_reg <= ST_LOAD;
            endcase
        end
    end

    // output item assembly: comp 0 is the mass item, comp j+1 the vector entry j
    logic [NW-1:0] cj;
    logic [IW-1:0] cjx;
    assign cj  = comp_reg - 1'b1;
    assign cjx = cj[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_OUT && out_free)
        begin
            if (comp_reg == '0)
            begin
                od_reg <= {3'b000, nc_reg, amat[k_reg][k_reg],
                           sat32({34'd0, srsp.root}), 2'b00, 2'(i_reg)};
                ou_reg <= 1'b0;
            end
            else
            begin
                od_reg <= {3'b000, nc_reg, 32'd0, vmat_reg[cjx][k_reg],
                           2'(cjx), 2'(i_reg)};
                ou_reg <= 1'b1;
            end
            ol_reg <= (NW'(comp_reg) == n_dim) && (NW'(ip1) >= n_dim);
        end
    end

    // shared unit requests
    always_comb
    begin
        dreq.start = 1'b0;
        dreq.num   = '0;
        dreq.den   = 64'd1;
        sreq.start = 1'b0;
        sreq.rad   = '0;
        case (st_reg)
            ST_DECIDE:
            begin
                dreq.start = best_reg > 32'(thr_reg) && rot_reg < maxr_reg;
                dreq.num   = mag64((64'(aqq) - 64'(app)) << FRACTION_BITS);
                dreq.den   = mag64(64'(apq)) << 1;
            end
            ST_T:
            begin
                if (th2_reg > 64'(th2lim_reg))
                begin
                    dreq.start = 1'b1;
                    dreq.num   = ONE_Q * ONE_Q;
                    dreq.den   = mag64(64'(theta_reg)) << 1;
                end
                else
                begin
                    sreq.start = 1'b1;
                    sreq.rad   = (ONE_Q + th2_reg) * ONE_Q;
                end
            end
            ST_TDEN:
            begin
                dreq.start = 1'b1;
                dreq.num   = ONE_Q * ONE_Q;
                dreq.den   = mag64(64'(theta_reg)) + 64'(srsp.root);
            end
            ST_T2:
            begin
                sreq.start = 1'b1;
                sreq.rad   = (ONE_Q + sq_val) * ONE_Q;
            end
            ST_CDIV:
            begin
                dreq.start = 1'b1;
                dreq.num   = ONE_Q * ONE_Q;
                dreq.den   = 64'(srsp.root);
            end
            ST_S:
            begin
                dreq.start = 1'b1;
                dreq.num   = mag64(64'(mul_q)) << FRACTION_BITS;
                dreq.den   = ONE_Q + 64'(c_reg);
            end
            ST_MASS:
            begin
                sreq.start = 1'b1;
                sreq.rad   = mag64(64'(amat[rank_reg[i_reg]][rank_reg[i_reg]]))
                             << FRACTION_BITS;
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tlast  = ol_reg;
    assign m_axis_tuser  = ou_reg;

    ap_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_LOAD) |-> !s_axis_tready)
        else $error("input accepted while solving");
    ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !m_axis_tready) |=> ov_reg && $stable(od_reg))
        else $error("result dropped under stall");
    ap_rot_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_DIAG) |-> (rot_reg < maxr_reg))
        else $error("rotation beyond cap");
endmodule

// File: sv/jes_div.sv
// ----------------------------------------------------------------------------
// jes_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module jes_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  jes_pkg::div_req_t req,
    output jes_pkg::div_rsp_t rsp
);
    import jes_pkg::*;

    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]} - {1'b0, den_reg};
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[62:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

// File: sv/jes_sqrt.sv
// ----------------------------------------------------------------------------
// jes_sqrt
// integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module jes_sqrt
(
    input  logic               clk,
    input  logic               rst_n,
    input  jes_pkg::sqrt_req_t req,
    output jes_pkg::sqrt_rsp_t rsp
);
    import jes_pkg::*;

    logic [63:0] x_reg, x_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb
    begin
        x_next    = x_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            x_next    = req.rad;
            r_next    = '0;
            bit_next  = 64'h4000_0000_0000_0000;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (x_reg >= r_reg + bit_reg)
            begin
                x_next = x_reg - (r_reg + bit_reg);
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
                r_next = r_reg >> 1;
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = r_reg[31:0];
endmodule

// File: verif/tb_jacobi_eigen_solver_core.sv
// ----------------------------------------------------------------------------
// tb_jacobi_eigen_solver_core
// self-checking bench for the jacobi eigen solver core: matrix loads go in
// through a queue-fed driver, a fixed-point jacobi predictor works out the
// ranked eigen results, and a monitor checks each result field by field
// ----------------------------------------------------------------------------
module tb_jacobi_eigen_solver_core;
    import jes_pkg::*;

    localparam int DIM = 4;
    localparam int FB = 16;
    localparam longint ONE_S = 64'sd65536;
    localparam longint unsigned ONE_U = 64'd65536;
    localparam int SETTLE = 40;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int TARGET_ITEMS = 480;

    typedef enum logic [1:0]
    {
        REG_MATRIX_SIZE = 2'd0,
        REG_OFFDIAG_THRESHOLD = 2'd1,
        REG_THETA_SQ_LIMIT = 2'd2,
        REG_MAX_ROTATIONS = 2'd3
    } reg_index_e;

    typedef enum logic
    {
        KIND_MASS = 1'b0,
        KIND_VECTOR = 1'b1
    } item_kind_e;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] data;
        bit          last;
    } request_t;

    typedef struct {
        item_kind_e  kind;
        logic [1:0]  rank;
        logic [1:0]  comp;
        logic [31:0] value;
        logic [31:0] eig;
        logic        nc;
        logic        last;
    } eigen_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    jacobi_eigen_solver_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    request_t      pending[$];
    eigen_result_t eigen_results[$];

    // solver state mirrored in the bench
    int          mat[DIM][DIM];
    int          vec[DIM][DIM];
    int unsigned size_reg;
    longint unsigned thr_reg;
    longint unsigned lim_reg;
    int unsigned rot_cap;
    bit          load_open;

    int          fails;
    int          items_in;
    int          quiet;
    int          idle_cycles;
    int          hold;
    bit          held_once;
    bit          calm;

    assign calm = (items_in >= 250) && (items_in < 330);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clip(input longint v);
        int r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = int'(v);
        return r;
    endfunction

    function automatic longint unsigned mabs(input longint v);
        longint unsigned r;
        r = (v < 0) ? longint'(-v) : longint'(v);
        return r;
    endfunction

    function automatic int qmul(input int a, input int b);
        longint p;
        longint m;
        p = longint'(a) * longint'(b);
        m = longint'(mabs(p) >> FB);
        return clip(p < 0 ? -m : m);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int dim_in_use();
        int n;
        n = (size_reg < 2) ? 2 : ((size_reg > DIM) ? DIM : int'(size_reg));
        return n;
    endfunction

    function automatic int tri_get(input int i, input int j);
        return (i <= j) ? mat[i][j] : mat[j][i];
    endfunction

    task automatic tri_set(input int i, input int j, input int v);
        if (i <= j)
            mat[i][j] = v;
        else
            mat[j][i] = v;
    endtask

    task automatic rotate_pair(inout int g, inout int h, input int s, input int tau);
        int a;
        int b;
        a = g;
        b = h;
        g = clip(longint'(a) - qmul(s, clip(longint'(b) + qmul(tau, a))));
        h = clip(longint'(b) + qmul(s, clip(longint'(a) - qmul(tau, b))));
    endtask

    // largest off-diagonal magnitude, pivot position through p and q
    task automatic search_pivot(input int n, output longint unsigned best,
                                output int p, output int q);
        longint unsigned m;
        best = 0;
        p = 0;
        q = 1;
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
            begin
                m = mabs(mat[i][j]);
                if (m > best)
                begin
                    best = m;
                    p = i;
                    q = j;
                end
            end
    endtask

    task automatic jacobi_rotate(input int n, input int p, input int q);
        int apq;
        longint diff;
        int theta;
        longint unsigned th2;
        longint unsigned root;
        longint t;
        int tq;
        longint unsigned t2;
        longint unsigned r;
        int c;
        int s;
        int tau;
        int shift;
        int g;
        int h;
        apq = mat[p][q];
        diff = longint'(mat[q][q]) - longint'(mat[p][p]);
        theta = clip((diff * ONE_S) / (2 * longint'(apq)));
        th2 = (mabs(theta) * mabs(theta)) >> FB;
        if (th2 > lim_reg)
            t = (ONE_S * ONE_S) / (2 * longint'(theta));
        else
        begin
            // small-angle form: t = 1 / (|theta| + sqrt(1 + theta^2))
            root = int_sqrt((ONE_U + th2) * ONE_U);
            t = (ONE_S * ONE_S) / longint'(mabs(theta) + root);
            if (theta < 0)
                t = -t;
        end
        tq = clip(t);
        t2 = (mabs(tq) * mabs(tq)) >> FB;
        r = int_sqrt((ONE_U + t2) * ONE_U);
        c = clip((ONE_S * ONE_S) / longint'(r));
        s = qmul(tq, c);
        tau = clip((longint'(s) * ONE_S) / (ONE_S + longint'(c)));
        shift = qmul(tq, apq);
        mat[p][p] = clip(longint'(mat[p][p]) - shift);
        mat[q][q] = clip(longint'(mat[q][q]) + shift);
        for (int i = 0; i < n; i++)
        begin
            if (i != p && i != q)
            begin
                g = tri_get(i, p);
                h = tri_get(i, q);
                rotate_pair(g, h, s, tau);
                tri_set(i, p, g);
                tri_set(i, q, h);
            end
        end
        mat[p][q] = 0;
        for (int i = 0; i < n; i++)
            rotate_pair(vec[i][p], vec[i][q], s, tau);
    endtask

    // one accepted element; the last one runs the whole solve
    task automatic predict_eigen(input logic [1:0] row_in, input logic [1:0] col_in,
                                 input logic [31:0] elem, input logic last_in);
        int n;
        int row;
        int col;
        int tmp;
        longint unsigned big;
        int p;
        int q;
        int unsigned count;
        logic nc;
        int order[DIM];
        bit used[DIM];
        int pick;
        bit have;
        longint unsigned least;
        longint unsigned m;
        int k;
        int lam;
        eigen_result_t er;
        n = dim_in_use();
        row = row_in;
        col = col_in;
        if (!load_open)
        begin
            for (int i = 0; i < DIM; i++)
                for (int j = 0; j < DIM; j++)
                    vec[i][j] = (i == j) ? int'(ONE_S) : 0;
            load_open = 1'b1;
        end
        if (row > col)
        begin
            tmp = row;
            row = col;
            col = tmp;
        end
        if (col < n)
            mat[row][col] = elem;
        if (last_in)
        begin
            load_open = 1'b0;
            count = 0;
            search_pivot(n, big, p, q);
            while (big > thr_reg && count < rot_cap)
            begin
                jacobi_rotate(n, p, q);
                count = (count + 1) & 16'hffff;
                search_pivot(n, big, p, q);
            end
            nc = (big > thr_reg);
            for (int i = 0; i < DIM; i++)
                used[i] = 1'b0;
            // ascending magnitude, ties to the lower index
            for (int i = 0; i < n; i++)
            begin
                pick = 0;
                have = 1'b0;
                least = 0;
                for (int j = 0; j < n; j++)
                begin
                    m = mabs(mat[j][j]);
                    if (!used[j] && (!have || m < least))
                    begin
                        pick = j;
                        least = m;
                        have = 1'b1;
                    end
                end
                used[pick] = 1'b1;
                order[i] = pick;
            end
            for (int i = 0; i < n; i++)
            begin
                k = order[i];
                lam = mat[k][k];
                er.kind = KIND_MASS;
                er.rank = i[1:0];
                er.comp = 2'd0;
                er.value = clip(longint'(int_sqrt(mabs(lam) << FB)));
                er.eig = lam;
                er.nc = nc;
                er.last = 1'b0;
                eigen_results.push_back(er);
                for (int j = 0; j < n; j++)
                begin
                    er.kind = KIND_VECTOR;
                    er.comp = j[1:0];
                    er.value = vec[j][k];
                    er.eig = 32'd0;
                    er.last = (i == n - 1) && (j == n - 1);
                    eigen_results.push_back(er);
                end
            end
        end
    endtask

    task automatic apply_register(input logic [1:0] idx, input logic [31:0] value);
        case (reg_index_e'(idx))
            REG_MATRIX_SIZE: size_reg = value & 32'h7;
            REG_OFFDIAG_THRESHOLD: thr_reg = value & 32'h7fffffff;
            REG_THETA_SQ_LIMIT: lim_reg = value & 32'h7fffffff;
            REG_MAX_ROTATIONS: rot_cap = value & 32'hffff;
            default: ;
        endcase
    endtask

    task automatic push_reg(input reg_index_e idx, input logic [31:0] value);
        request_t r;
        r.is_cfg = 1'b1;
        r.row = idx;
        r.col = 2'd0;
        r.data = value;
        r.last = 1'b0;
        pending.push_back(r);
    endtask

    task automatic push_elem(input int row, input int col, input logic [31:0] value,
                             input bit last);
        request_t r;
        r.is_cfg = 1'b0;
        r.row = row[1:0];
        r.col = col[1:0];
        r.data = value;
        r.last = last;
        pending.push_back(r);
    endtask

    function automatic logic [31:0] rand_element();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom;
            1: v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2: v = 32'd0;
            default: v = $urandom_range(0, 32'h1fffff) - 32'h100000;
        endcase
        return v;
    endfunction

    // every upper element of an n x n load in shuffled order, last on the final
    task automatic push_full_load(input int n, output int pushed);
        int ri[$];
        int ci[$];
        int a;
        int b;
        int tmp;
        for (int i = 0; i < n; i++)
            for (int j = i; j < n; j++)
            begin
                ri.push_back(i);
                ci.push_back(j);
            end
        for (int i = ri.size() - 1; i > 0; i--)
        begin
            a = $urandom_range(0, i);
            tmp = ri[i]; ri[i] = ri[a]; ri[a] = tmp;
            tmp = ci[i]; ci[i] = ci[a]; ci[a] = tmp;
        end
        for (int i = 0; i < ri.size(); i++)
        begin
            a = ri[i];
            b = ci[i];
            if ($urandom_range(0, 3) == 0)
                push_elem(b, a, rand_element(), i == ri.size() - 1);
            else
                push_elem(a, b, rand_element(), i == ri.size() - 1);
        end
        pushed = ri.size();
    endtask

    task automatic build_stimulus();
        int total;
        int n;
        int got;
        int cnt;
        int a;
        int b;
        push_reg(REG_MAX_ROTATIONS, 32'd64);
        // diagonal extremes, a swapped element, full load at the largest size
        push_elem(0, 0, 32'h7fffffff, 1'b0);
        push_elem(1, 1, 32'h80000000, 1'b0);
        push_elem(2, 2, 32'h00000000, 1'b0);
        push_elem(3, 3, 32'h00000001, 1'b0);
        push_elem(1, 0, 32'h00030000, 1'b0);
        push_elem(0, 2, 32'hfffe8000, 1'b0);
        push_elem(0, 3, 32'h00001234, 1'b0);
        push_elem(1, 2, 32'h7fffffff, 1'b0);
        push_elem(1, 3, 32'h80000000, 1'b0);
        push_elem(2, 3, 32'h00010000, 1'b1);
        // smallest size: out-of-range writes are dropped, last still fires
        push_reg(REG_MATRIX_SIZE, 32'd2);
        push_reg(REG_THETA_SQ_LIMIT, 32'd0);
        push_elem(0, 1, 32'h00020000, 1'b0);
        push_elem(3, 3, 32'h12345678, 1'b0);
        push_elem(1, 1, 32'hffff0000, 1'b0);
        push_elem(2, 3, 32'h00000000, 1'b1);
        // huge threshold and cap: no rotation at all
        push_reg(REG_MATRIX_SIZE, 32'd3);
        push_reg(REG_OFFDIAG_THRESHOLD, 32'h7fffffff);
        push_reg(REG_MAX_ROTATIONS, 32'd65535);
        push_elem(0, 1, 32'h40000000, 1'b0);
        push_elem(2, 2, 32'hc0000000, 1'b1);
        // zero threshold with a single rotation: not converged
        push_reg(REG_OFFDIAG_THRESHOLD, 32'd0);
        push_reg(REG_MAX_ROTATIONS, 32'd1);
        push_reg(REG_THETA_SQ_LIMIT, 32'h7fffffff);
        push_elem(0, 2, 32'h00050000, 1'b0);
        push_elem(1, 2, 32'hfff00000, 1'b0);
        push_elem(1, 1, 32'h00050000, 1'b1);
        total = 21;
        n = 3;
        while (total < TARGET_ITEMS)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                n = $urandom_range(2, 4);
                push_reg(REG_MATRIX_SIZE, n);
                case ($urandom_range(0, 3))
                    0: push_reg(REG_OFFDIAG_THRESHOLD, 32'd0);
                    1: push_reg(REG_OFFDIAG_THRESHOLD, 32'd1);
                    2: push_reg(REG_OFFDIAG_THRESHOLD, $urandom_range(1, 4096));
                    default: push_reg(REG_OFFDIAG_THRESHOLD, $urandom & 32'h7fffffff);
                endcase
                case ($urandom_range(0, 3))
                    0: push_reg(REG_THETA_SQ_LIMIT, 32'd0);
                    1: push_reg(REG_THETA_SQ_LIMIT, 32'h7fffffff);
                    2: push_reg(REG_THETA_SQ_LIMIT, $urandom_range(0, 32'h100000));
                    default: push_reg(REG_THETA_SQ_LIMIT, $urandom & 32'h7fffffff);
                endcase
                push_reg(REG_MAX_ROTATIONS, $urandom_range(1, 48));
            end
            case ($urandom_range(0, 9))
                0:
                begin
                    // partial reload, the rest keeps earlier values
                    cnt = $urandom_range(1, 3);
                    for (int i = 0; i < cnt; i++)
                    begin
                        a = $urandom_range(0, n - 1);
                        b = $urandom_range(0, n - 1);
                        push_elem(a, b, rand_element(), i == cnt - 1);
                    end
                    total += cnt;
                end
                1:
                begin
                    // noise: column 3, beyond the size in use unless it is 4, then a last
                    cnt = $urandom_range(1, 3);
                    for (int i = 0; i < cnt; i++)
                        push_elem($urandom_range(0, 3), 3, $urandom, 1'b0);
                    push_elem($urandom_range(0, 3), $urandom_range(0, 3), $urandom, 1'b1);
                    total += 1;
                end
                default:
                begin
                    push_full_load(n, got);
                    total += got;
                end
            endcase
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        request_t r;
        logic nv;
        logic we;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
            cfg_we <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
        end
        else
        begin
            nv = s_axis_tvalid;
            we = 1'b0;
            if (s_axis_tvalid && s_axis_tready)
                nv = 1'b0;
            if (!nv && pending.size() > 0)
            begin
                r = pending[0];
                if (r.is_cfg)
                begin
                    if (!s_axis_tvalid && quiet >= SETTLE)
                    begin
                        we = 1'b1;
                        cfg_index <= r.row;
                        cfg_data <= r.data[30:0];
                        apply_register(r.row, r.data);
                        void'(pending.pop_front());
                    end
                end
                else if (calm || $urandom_range(0, 99) >= 36)
                begin
                    nv = 1'b1;
                    s_axis_tdata <= {4'd0, r.data, r.col, r.row};
                    s_axis_tlast <= r.last;
                    void'(pending.pop_front());
                end
            end
            s_axis_tvalid <= nv;
            cfg_we <= we;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_eigen(s_axis_tdata[1:0], s_axis_tdata[3:2], s_axis_tdata[35:4],
                          s_axis_tlast);
            items_in <= items_in + 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet <= 0;
        else if (s_axis_tvalid || eigen_results.size() != 0)
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    // receiver, with one long hold-off so the core backs up its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold <= 0;
            held_once <= 1'b0;
        end
        else if (!held_once && items_in >= 120)
        begin
            held_once <= 1'b1;
            hold <= 3000;
            m_axis_tready <= 1'b0;
        end
        else if (hold > 0)
        begin
            hold <= hold - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 36);
    end

    // result monitor
    always @(posedge clk)
    begin
        eigen_result_t er;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (eigen_results.size() == 0)
            begin
                $error("result with no expectation: data %h", m_axis_tdata);
                fails++;
            end
            else
            begin
                er = eigen_results.pop_front();
                if (m_axis_tuser !== er.kind)
                begin
                    $error("item_kind: expected %0d, got %0d", er.kind, m_axis_tuser);
                    fails++;
                end
                if (m_axis_tdata[1:0] !== er.rank)
                begin
                    $error("rank_index: expected %0d, got %0d", er.rank, m_axis_tdata[1:0]);
                    fails++;
                end
                if (m_axis_tdata[3:2] !== er.comp)
                begin
                    $error("component_index: expected %0d, got %0d", er.comp,
                           m_axis_tdata[3:2]);
                    fails++;
                end
                if (m_axis_tdata[35:4] !== er.value)
                begin
                    $error("out_value: expected %h, got %h", er.value, m_axis_tdata[35:4]);
                    fails++;
                end
                if (m_axis_tdata[67:36] !== er.eig)
                begin
                    $error("eigen_value: expected %h, got %h", er.eig, m_axis_tdata[67:36]);
                    fails++;
                end
                if (m_axis_tdata[68] !== er.nc)
                begin
                    $error("not_converged: expected %0d, got %0d", er.nc, m_axis_tdata[68]);
                    fails++;
                end
                if (m_axis_tlast !== er.last)
                begin
                    $error("last_result: expected %0d, got %0d", er.last, m_axis_tlast);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        fails = 0;
        items_in = 0;
        idle_cycles = 0;
        size_reg = 4;
        thr_reg = 1;
        lim_reg = 64'h7fffffff;
        rot_cap = 1024;
        load_open = 1'b0;
        for (int i = 0; i < DIM; i++)
            for (int j = 0; j < DIM; j++)
            begin
                mat[i][j] = 0;
                vec[i][j] = (i == j) ? int'(ONE_S) : 0;
            end
        rst_n = 1'b0;
        build_stimulus();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!(pending.size() == 0 && eigen_results.size() == 0 && quiet >= 200))
            @(posedge clk);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
